// ===== hdl/fat_pkg.sv =====
// Shared types and constants for the allocation table chain engine.
package fat_pkg;

    localparam int ACTION_W  = 2;
    localparam int BLOCK_A_W = 11;
    localparam int BLOCK_B_W = 10;
    localparam int LINKS_W   = 10;
    localparam int VALUE_W   = 11;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DECODE,
        ST_ADD_NEW_WT,
        ST_ADD_TAIL_RD,
        ST_ADD_TAIL_WT,
        ST_LK_RD,
        ST_LK_WT,
        ST_RM_FIND_RD,
        ST_RM_FIND_WT,
        ST_RM_FREE_RD,
        ST_RM_FREE_WT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] value;
    } res_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

// ===== hdl/fat_mem.sv =====
// Single-port table memory with registered read data.
module fat_mem #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int EW            = 11
) (
    input  logic                             clk,
    input  fat_pkg::mem_cmd_t                cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] addr,
    input  logic [EW-1:0]                    wdata,
    output logic [EW-1:0]                    rdata
);
    import fat_pkg::*;

    logic [EW-1:0] mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        else if (cmd.rd)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== hdl/fat_seq.sv =====
// Sequencer: decodes actions and walks chains through the table memory.
module fat_seq #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int AW            = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fat_pkg::ACTION_W-1:0]   action,
    input  logic [fat_pkg::BLOCK_A_W-1:0]  block_a,
    input  logic [fat_pkg::BLOCK_B_W-1:0]  block_b,
    input  logic [fat_pkg::LINKS_W-1:0]    logical_index,
    output logic                           res_valid,
    input  logic                           res_ready,
    output fat_pkg::res_t                  res,
    output fat_pkg::mem_cmd_t              mem_cmd,
    output logic [AW-1:0]                  mem_addr,
    output logic [AW:0]                    mem_wdata,
    input  logic [AW:0]                    mem_rdata
);
    import fat_pkg::*;

    localparam int CW = ((AW > BLOCK_B_W) ? AW : BLOCK_B_W) + 1;
    localparam logic [CW-1:0] N_CMP  = CW'(TABLE_ENTRIES);
    localparam logic [AW:0]   N_CNT  = (AW + 1)'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST   = AW'(TABLE_ENTRIES - 1);
    localparam logic [AW:0]   END_ENTRY  = {1'b1, {AW{1'b0}}};
    localparam logic [AW:0]   FREE_ENTRY = '0;

    state_t                 state_reg, state_next;
    logic                   sweep_resp_reg, sweep_resp_next;
    logic [AW-1:0]          cur_reg, cur_next;
    logic [ACTION_W-1:0]    act_reg;
    logic [BLOCK_A_W-1:0]   a_reg;
    logic [BLOCK_B_W-1:0]   b_reg;
    logic [LINKS_W-1:0]     rem_reg, rem_next;
    logic [AW-1:0]          steps_reg, steps_next;
    logic [AW:0]            count_reg, count_next;
    logic                   first_reg, first_next;
    res_t                   res_reg, res_next;

    logic          accept;
    logic          a_ok, a_none, b_ok;
    logic [AW-1:0] a_idx, b_idx;
    logic          d_free, d_end, d_next;
    logic [AW-1:0] d_link;
    logic [AW:0]   cnt_inc;

    assign accept  = in_valid && in_ready;
    assign a_ok    = !a_reg[BLOCK_A_W-1] && (CW'(a_reg[BLOCK_A_W-2:0]) < N_CMP);
    assign a_none  = (a_reg == '1);
    assign b_ok    = CW'(b_reg) < N_CMP;
    assign a_idx   = AW'(a_reg[BLOCK_A_W-2:0]);
    assign b_idx   = AW'(b_reg);
    assign d_free  = (mem_rdata == FREE_ENTRY);
    assign d_end   = mem_rdata[AW];
    assign d_link  = mem_rdata[AW-1:0];
    assign d_next  = !d_end && (d_link != '0);
    assign cnt_inc = count_reg + 1'b1;
    assign res     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_resp_reg <= 1'b0;
            cur_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_resp_reg <= sweep_resp_next;
            cur_reg        <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            a_reg   <= block_a;
            b_reg   <= block_b;
        end
        rem_reg   <= rem_next;
        steps_reg <= steps_next;
        count_reg <= count_next;
        first_reg <= first_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_resp_next = sweep_resp_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        steps_next      = steps_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        res_next        = res_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_cmd         = '0;
        mem_addr        = cur_reg;
        mem_wdata       = FREE_ENTRY;

        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_cmd.wr = 1'b1;
                if (cur_reg == LAST)
                begin
                    cur_next = '0;
                    if (sweep_resp_reg)
                    begin
                        res_next   = '{STATUS_OK, '0};
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rem_next   = logical_index;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                steps_next = '0;
                count_next = '0;
                first_next = 1'b1;
                unique case (act_reg)
                    ACT_ADD:
                    begin
                        if (!b_ok || !(a_none || a_ok))
                        begin
                            res_next   = '{STATUS_ERR, '0};
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            mem_cmd.rd = 1'b1;
                            mem_addr   = b_idx;
                            state_next = ST_ADD_NEW_WT;
                        end
                    end
                    ACT_LOOKUP, ACT_REMOVE:
                    begin
                        if (!a_ok || (act_reg == ACT_REMOVE && !b_ok))
                        begin
                            res_next   = '{STATUS_ERR, '0};
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            cur_next   = a_idx;
                            state_next = (act_reg == ACT_LOOKUP) ? ST_LK_RD : ST_RM_FIND_RD;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cur_next        = '0;
                        sweep_resp_next = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_ADD_NEW_WT:
            begin
                if (!d_free)
                begin
                    res_next   = '{STATUS_ERR, '0};
                    state_next = ST_RESP;
                end
                else
                begin
                    mem_cmd.wr = 1'b1;
                    mem_addr   = b_idx;
                    mem_wdata  = END_ENTRY;
                    if (a_none)
                    begin
                        res_next   = '{STATUS_OK, '0};
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_ADD_TAIL_RD;
                    end
                end
            end

            ST_ADD_TAIL_RD:
            begin
                mem_cmd.rd = 1'b1;
                mem_addr   = a_idx;
                state_next = ST_ADD_TAIL_WT;
            end

            ST_ADD_TAIL_WT:
            begin
                // new block stays claimed even when the tail is not a chain end
                if (mem_rdata != END_ENTRY)
                begin
                    res_next = '{STATUS_ERR, '0};
                end
                else
                begin
                    mem_cmd.wr = 1'b1;
                    mem_addr   = a_idx;
                    mem_wdata  = {1'b0, b_idx};
                    res_next   = '{STATUS_OK, VALUE_W'(1)};
                end
                state_next = ST_RESP;
            end

            ST_LK_RD:
            begin
                mem_cmd.rd = 1'b1;
                state_next = ST_LK_WT;
            end

            ST_LK_WT:
            begin
                if (first_reg && d_free)
                begin
                    res_next   = '{STATUS_ERR, '0};
                    state_next = ST_RESP;
                end
                else if (rem_reg == '0)
                begin
                    res_next   = '{STATUS_OK, VALUE_W'(cur_reg)};
                    state_next = ST_RESP;
                end
                else if (!d_next)
                begin
                    res_next   = '{STATUS_ERR, '0};
                    state_next = ST_RESP;
                end
                else
                begin
                    cur_next   = d_link;
                    rem_next   = rem_reg - 1'b1;
                    first_next = 1'b0;
                    state_next = ST_LK_RD;
                end
            end

            ST_RM_FIND_RD:
            begin
                mem_cmd.rd = 1'b1;
                state_next = ST_RM_FIND_WT;
            end

            ST_RM_FIND_WT:
            begin
                if (!d_next)
                begin
                    res_next   = '{STATUS_ERR, '0};
                    state_next = ST_RESP;
                end
                else if (d_link == b_idx)
                begin
                    // cut the chain here, then free from the start block on
                    mem_cmd.wr = 1'b1;
                    mem_wdata  = END_ENTRY;
                    cur_next   = b_idx;
                    state_next = ST_RM_FREE_RD;
                end
                else if (steps_reg == LAST)
                begin
                    res_next   = '{STATUS_ERR, '0};
                    state_next = ST_RESP;
                end
                else
                begin
                    cur_next   = d_link;
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_RM_FIND_RD;
                end
            end

            ST_RM_FREE_RD:
            begin
                mem_cmd.rd = 1'b1;
                state_next = ST_RM_FREE_WT;
            end

            ST_RM_FREE_WT:
            begin
                mem_cmd.wr = 1'b1;
                mem_wdata  = FREE_ENTRY;
                count_next = cnt_inc;
                if (d_next && (cnt_inc < N_CNT))
                begin
                    cur_next   = d_link;
                    state_next = ST_RM_FREE_RD;
                end
                else
                begin
                    res_next   = '{STATUS_OK, VALUE_W'(cnt_inc)};
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    sweep_resp_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fat_chain_table_engine_unit.sv =====
// Top level of the allocation table chain engine: sequencer, table memory, output register.
// Lookup walks logical_index links, remove searches the chain for the link to block_b and then
// frees entries one by one, and clear sweeps every table entry; errors end the transaction sooner.
// One transaction at a time: in_ready rises in the same cycle as out_valid, once the result has moved
// into the output register; each chain link costs a read and a check/write of the table.
// After rst_n releases, a sweep zeroes every table entry before in_ready.
module fat_chain_table_engine_unit #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fat_pkg::ACTION_W-1:0]  action,
    input  logic signed [fat_pkg::BLOCK_A_W-1:0] block_a,
    input  logic [fat_pkg::BLOCK_B_W-1:0] block_b,
    input  logic [fat_pkg::LINKS_W-1:0]   logical_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic [fat_pkg::VALUE_W-1:0]   value
);
    import fat_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int EW = AW + 1;

    logic          res_valid;
    logic          res_ready;
    res_t          res;
    mem_cmd_t      mem_cmd;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;
    logic [EW-1:0] mem_rdata;

    logic               out_valid_reg;
    logic               status_reg;
    logic [VALUE_W-1:0] value_reg;

    fat_seq #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .AW           (AW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .block_a      (block_a),
        .block_b      (block_b),
        .logical_index(logical_index),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_cmd      (mem_cmd),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata)
    );

    fat_mem #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .EW           (EW)
    ) u_mem (
        .clk  (clk),
        .cmd  (mem_cmd),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            status_reg <= res.status;
            value_reg  <= res.value;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

`ifndef SYNTHESIS
    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_ERR) |-> (value == '0))
        else $error("error result carries nonzero value");

    a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> out_valid)
        else $error("sequencer result lost before output register");

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_cmd.rd && mem_cmd.wr))
        else $error("table memory read and write in one cycle");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.wr |-> ((EW)'(mem_addr) < (EW)'(TABLE_ENTRIES)))
        else $error("table write beyond last entry");

    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !in_ready)
        else $error("input taken while a result is pending in the sequencer");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the allocation table chain engine.
`timescale 1ns / 1ps

module tb_top;
    import fat_pkg::*;

    localparam int TBL_N = 1024;
    localparam int END_MARK = -1;

    typedef struct packed {
        logic [ACTION_W-1:0]         act;
        logic signed [BLOCK_A_W-1:0] a;
        logic [BLOCK_B_W-1:0]        b;
        logic [LINKS_W-1:0]          links;
        logic                        typed;
        res_t                        res;
    } txn_t;

    typedef enum {PICK_FREE, PICK_END, PICK_HEAD} pick_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [ACTION_W-1:0]         action;
    logic signed [BLOCK_A_W-1:0] block_a;
    logic [BLOCK_B_W-1:0]        block_b;
    logic [LINKS_W-1:0]          logical_index;
    logic                        out_valid;
    logic                        out_ready;
    logic                        status;
    logic [VALUE_W-1:0]          value;

    int   fat_tbl [TBL_N];
    res_t replies_due [$];
    txn_t dir_rows [$];
    int   bad_count;
    int   tx_idle_pct;
    int   rx_idle_pct;

    fat_chain_table_engine_unit #(.TABLE_ENTRIES(TBL_N)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .block_a(block_a),
        .block_b(block_b),
        .logical_index(logical_index),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .value(value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit blk_ok(int b);
        return b >= 0 && b < TBL_N;
    endfunction

    // Applies one transaction to the local table copy and returns the reply.
    function automatic res_t table_step(logic [ACTION_W-1:0] act, int a, int b, int links);
        res_t r;
        int   cur;
        int   nxt;
        int   cnt;
        int   i;
        bit   found;
        bit   stop;
        r.status = STATUS_OK;
        r.value  = '0;
        cur = a;
        nxt = 0;
        cnt = 0;
        found = 1'b0;
        stop = 1'b0;
        case (act)
            ACT_ADD:
            begin
                if (!blk_ok(b) || (a != END_MARK && !blk_ok(a)) || fat_tbl[b] != 0)
                    r.status = STATUS_ERR;
                else
                begin
                    fat_tbl[b] = END_MARK;
                    if (a != END_MARK)
                    begin
                        // new block stays claimed even when the tail is rejected
                        if (fat_tbl[a] != END_MARK)
                            r.status = STATUS_ERR;
                        else
                        begin
                            fat_tbl[a] = b;
                            r.value = VALUE_W'(1);
                        end
                    end
                end
            end
            ACT_LOOKUP:
            begin
                if (!blk_ok(a) || fat_tbl[a] == 0)
                    r.status = STATUS_ERR;
                else
                begin
                    for (i = 0; i < links && !stop; i++)
                    begin
                        cur = fat_tbl[cur];
                        if (cur <= 0)
                            stop = 1'b1;
                    end
                    if (stop)
                        r.status = STATUS_ERR;
                    else
                        r.value = VALUE_W'(cur);
                end
            end
            ACT_REMOVE:
            begin
                if (!blk_ok(a) || !blk_ok(b))
                    r.status = STATUS_ERR;
                else
                begin
                    for (i = 0; i < TBL_N && !stop; i++)
                    begin
                        nxt = fat_tbl[cur];
                        if (nxt <= 0)
                            stop = 1'b1;
                        else if (nxt == b)
                        begin
                            found = 1'b1;
                            stop = 1'b1;
                        end
                        else
                            cur = nxt;
                    end
                    if (!found)
                        r.status = STATUS_ERR;
                    else
                    begin
                        fat_tbl[cur] = END_MARK;
                        cur = nxt;
                        while (cur > 0 && cnt < TBL_N)
                        begin
                            nxt = fat_tbl[cur];
                            fat_tbl[cur] = 0;
                            cnt++;
                            cur = nxt;
                        end
                        r.value = VALUE_W'(cnt);
                    end
                end
            end
            default:
            begin
                for (i = 0; i < TBL_N; i++)
                    fat_tbl[i] = 0;
            end
        endcase
        return r;
    endfunction

    // Random block of the given kind from the current table, or -1 if none exists.
    function automatic int pick_block(pick_t kind);
        bit linked [TBL_N];
        int cand [$];
        int i;
        for (i = 0; i < TBL_N; i++)
            linked[i] = 1'b0;
        for (i = 0; i < TBL_N; i++)
            if (fat_tbl[i] > 0)
                linked[fat_tbl[i]] = 1'b1;
        for (i = 0; i < TBL_N; i++)
        begin
            case (kind)
                PICK_FREE: if (fat_tbl[i] == 0) cand.push_back(i);
                PICK_END:  if (fat_tbl[i] == END_MARK) cand.push_back(i);
                default:   if (fat_tbl[i] != 0 && !linked[i]) cand.push_back(i);
            endcase
        end
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    function automatic int chain_len(int head);
        int cur;
        int n;
        cur = head;
        n = 0;
        while (n < TBL_N && fat_tbl[cur] > 0)
        begin
            cur = fat_tbl[cur];
            n++;
        end
        return n;
    endfunction

    function automatic int chain_node(int head, int k);
        int cur;
        int i;
        cur = head;
        for (i = 0; i < k && fat_tbl[cur] > 0; i++)
            cur = fat_tbl[cur];
        return cur;
    endfunction

    // Mostly well-formed chain building and walking, with some raw noise.
    function automatic txn_t random_txn();
        txn_t r;
        int   roll;
        int   a;
        int   b;
        int   len;
        r.act   = ACT_ADD;
        r.a     = BLOCK_A_W'($urandom_range(2047));
        r.b     = BLOCK_B_W'($urandom_range(1023));
        r.links = LINKS_W'($urandom_range(1023));
        r.typed = 1'b0;
        r.res   = '0;
        roll = $urandom_range(99);
        if (roll < 2)
            r.act = ACT_CLEAR;
        else if (roll < 48)
        begin
            b = pick_block(PICK_FREE);
            if (b >= 0)
                r.b = BLOCK_B_W'(b);
            if (roll < 26)
                r.a = BLOCK_A_W'(END_MARK);
            else if (roll < 46)
            begin
                a = pick_block(PICK_END);
                r.a = BLOCK_A_W'((a >= 0) ? a : END_MARK);
            end
            else
                r.a = {1'b0, r.b};
        end
        else if (roll < 80)
        begin
            a = pick_block(PICK_HEAD);
            if (a < 0)
                a = $urandom_range(TBL_N - 1);
            r.a = BLOCK_A_W'(a);
            len = chain_len(a);
            if (roll < 66)
            begin
                r.act = ACT_LOOKUP;
                if ($urandom_range(19) != 0)
                    r.links = LINKS_W'($urandom_range(len + 1));
            end
            else
            begin
                r.act = ACT_REMOVE;
                if (len > 0)
                    r.b = BLOCK_B_W'(chain_node(a, $urandom_range(len, 1)));
            end
        end
        else
            r.act = ACTION_W'($urandom_range(2));
        return r;
    endfunction

    task automatic add_row(logic [ACTION_W-1:0] act, int a, int b, int links,
                           logic typed, logic st, int val);
        txn_t r;
        r.act   = act;
        r.a     = BLOCK_A_W'(a);
        r.b     = BLOCK_B_W'(b);
        r.links = LINKS_W'(links);
        r.typed = typed;
        r.res.status = st;
        r.res.value  = VALUE_W'(val);
        dir_rows.push_back(r);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic drive_txn(txn_t r);
        res_t due;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= r.act;
        block_a       <= r.a;
        block_b       <= r.b;
        logical_index <= r.links;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        due = table_step(r.act, $signed(r.a), r.b, r.links);
        if (r.typed)
            due = r.res;
        replies_due.push_back(due);
        @(negedge clk);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_mismatch(string what, int want, int got);
        bad_count++;
        if (bad_count <= 10)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
                note_mismatch("unexpected transaction", -1, value);
            else
            begin
                want = replies_due.pop_front();
                if (status !== want.status)
                    note_mismatch("status", want.status, status);
                if (value !== want.value)
                    note_mismatch("value", want.value, value);
            end
        end
    end

    initial
    begin
        #100000000;
        $display("FAIL fat_chain_table_engine_unit");
        $finish;
    end

    initial
    begin
        int k;
        int phase;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_ADD;
        block_a       = '0;
        block_b       = '0;
        logical_index = '0;
        out_ready     = 1'b0;
        bad_count     = 0;
        tx_idle_pct   = 14;
        rx_idle_pct   = 80;
        for (k = 0; k < TBL_N; k++)
            fat_tbl[k] = 0;

        // empty table, then a chain 0 -> 1023 -> 5
        add_row(ACT_LOOKUP, 0, 0, 0, 1, STATUS_ERR, 0);
        add_row(ACT_REMOVE, 0, 1, 0, 1, STATUS_ERR, 0);
        add_row(ACT_ADD, -1, 0, 0, 1, STATUS_OK, 0);
        add_row(ACT_ADD, 0, 1023, 0, 1, STATUS_OK, 1);
        add_row(ACT_ADD, 1023, 5, 0, 1, STATUS_OK, 1);
        add_row(ACT_LOOKUP, 0, 0, 2, 0, STATUS_OK, 0);
        add_row(ACT_LOOKUP, 0, 0, 3, 1, STATUS_ERR, 0);
        add_row(ACT_LOOKUP, 0, 0, 1023, 1, STATUS_ERR, 0);
        // bad tails, tail not an end (7 still claimed), block already taken
        add_row(ACT_ADD, -1024, 7, 0, 1, STATUS_ERR, 0);
        add_row(ACT_ADD, -2, 7, 0, 1, STATUS_ERR, 0);
        add_row(ACT_ADD, 1023, 7, 0, 1, STATUS_ERR, 0);
        add_row(ACT_ADD, -1, 7, 0, 1, STATUS_ERR, 0);
        // block linked to itself
        add_row(ACT_ADD, 9, 9, 0, 1, STATUS_OK, 1);
        add_row(ACT_LOOKUP, 9, 0, 1000, 0, STATUS_OK, 0);
        add_row(ACT_REMOVE, 9, 9, 0, 0, STATUS_OK, 0);
        add_row(ACT_LOOKUP, -1, 0, 0, 1, STATUS_ERR, 0);
        add_row(ACT_LOOKUP, 1023, 0, 1, 0, STATUS_OK, 0);
        add_row(ACT_REMOVE, 0, 1023, 0, 0, STATUS_OK, 0);
        add_row(ACT_REMOVE, -5, 0, 0, 1, STATUS_ERR, 0);
        add_row(ACT_CLEAR, 0, 0, 0, 1, STATUS_OK, 0);
        // link into block 0 reads as free
        add_row(ACT_ADD, -1, 30, 0, 1, STATUS_OK, 0);
        add_row(ACT_ADD, 30, 0, 0, 1, STATUS_OK, 1);
        add_row(ACT_LOOKUP, 30, 0, 1, 1, STATUS_ERR, 0);
        add_row(ACT_REMOVE, 30, 0, 0, 1, STATUS_ERR, 0);
        // start never found on a loop: search bound hits
        add_row(ACT_ADD, 50, 50, 0, 1, STATUS_OK, 1);
        add_row(ACT_REMOVE, 50, 51, 0, 1, STATUS_ERR, 0);
        add_row(ACT_CLEAR, -1, 1023, 1023, 1, STATUS_OK, 0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < dir_rows.size(); k++)
            drive_txn(dir_rows[k]);

        for (phase = 0; phase < 3; phase++)
        begin
            for (k = 0; k < 367; k++)
                drive_txn(random_txn());
            // hold the sender until the engine has answered everything
            drain_replies();
            tx_idle_pct = (phase == 0) ? 80 : 0;
            rx_idle_pct = (phase == 0) ? 14 : 0;
        end

        repeat (4 * TBL_N) @(posedge clk);
        if (bad_count == 0)
            $display("PASS fat_chain_table_engine_unit");
        else
            $display("FAIL fat_chain_table_engine_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fat_pkg.sv
hdl/fat_mem.sv
hdl/fat_seq.sv
hdl/fat_chain_table_engine_unit.sv
bench/tb_top.sv
